// ===== hw/rtl/rgbi_pkg.sv =====
// rgbi_pkg: item types, register indexes and fixed constants of the radial grid interpolator
// used by the interpolator and its checker; depends on nothing
`default_nettype none

package rgbi_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ORIGIN    = 3'd0,
    REG_R_ORIGIN    = 3'd1,
    REG_X_SCALE     = 3'd2,
    REG_R_SCALE     = 3'd3,
    REG_VALUE_FLOOR = 3'd4,
    REG_USED_COLS   = 3'd5,
    REG_USED_ROWS   = 3'd6
  } reg_idx_t;

  // operation codes of an input item
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // reset values of the registers
  localparam logic [31:0] RST_X_ORIGIN    = 32'd0;
  localparam logic [31:0] RST_R_ORIGIN    = 32'd0;
  localparam logic [31:0] RST_X_SCALE     = 32'd65536;
  localparam logic [31:0] RST_R_SCALE     = 32'd65536;
  localparam logic [47:0] RST_VALUE_FLOOR = 48'd66;   // about 1.0e-3 in q32.16
  localparam logic [7:0]  RST_USED_COLS   = 8'd97;
  localparam logic [7:0]  RST_USED_ROWS   = 8'd100;

  // one in q1.16
  localparam logic [16:0] FRAC_ONE = 17'h10000;

  typedef struct packed {
    logic        operation;
    logic [6:0]  entry_row;
    logic [6:0]  entry_col;
    logic [47:0] entry_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic [47:0] interpolated_value;
    logic        out_of_range;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rgbi_ram.sv =====
// rgbi_ram: generic simple dual port ram, one write and one registered read per cycle
// standalone, no package needed
`default_nettype none

module rgbi_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/radial_grid_bilinear_interp.sv =====
// one item per cycle sustained while the output buffer has room; the input stalls while it is full
// the datapath is fully pipelined (16-stage square root, banked table)
// a 2-entry output buffer lets items keep entering while one result waits
// reset (rst, synchronous, active high) clears valid bits and registers to defaults
// the value table is not cleared; entries read before being written are undefined
`default_nettype none

module radial_grid_bilinear_interp #(
  parameter int GRID_ROWS = 128,
  parameter int GRID_COLS = 128
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire rgbi_pkg::in_item_t                 in_item,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output rgbi_pkg::out_item_t                     out_item,
  input  wire logic                               cfg_write,
  input  wire logic [rgbi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rgbi_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import rgbi_pkg::*;

  // grid geometry; the table is split into four banks by row and column parity
  // so that the four corners of any cell land in four different banks
  localparam int CIW       = $clog2(GRID_COLS);
  localparam int RIW       = $clog2(GRID_ROWS);
  localparam int LIW       = (CIW > RIW) ? CIW : RIW;
  localparam int HR        = (GRID_ROWS + 1) / 2;
  localparam int HC        = (GRID_COLS + 1) / 2;
  localparam int BDEPTH    = HR * HC;
  localparam int AW        = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int SQ_STAGES = 16;   // two root bits per stage

  typedef struct packed {
    logic [LIW-1:0] idx;
    logic [16:0]    frac;
    logic           oor;
  } loc_t;

  // digit-by-digit square root state
  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_t;

  // what travels next to the square root
  typedef struct packed {
    logic           op;
    logic [6:0]     row;
    logic [6:0]     col;
    logic [47:0]    val;
    logic [CIW-1:0] cx;
    logic [16:0]    fx;
    logic           oorx;
  } cry_t;

  // one root bit
  function automatic sq_t sq_step(input sq_t s);
    logic [35:0] r2;
    logic [35:0] trial;
    sq_t         n;
    r2    = {s.rem[33:0], s.rad[63:62]};
    trial = {2'b00, s.root, 2'b01};
    n.rad = {s.rad[61:0], 2'b00};
    if (r2 >= trial) begin
      n.rem  = r2 - trial;
      n.root = {s.root[30:0], 1'b1};
    end else begin
      n.rem  = r2;
      n.root = {s.root[30:0], 1'b0};
    end
    return n;
  endfunction

  // cell index and fraction on an axis whose last node index is nm1
  function automatic loc_t locate(input logic zs, input logic neg, input logic big,
                                  input logic [39:0] t, input logic [LIW-1:0] nm1);
    logic [39:0] lim;
    loc_t        l;
    lim    = 40'(nm1) << 16;
    l.idx  = '0;
    l.frac = '0;
    l.oor  = 1'b0;
    if (!zs) begin
      if (neg) begin
        l.oor = 1'b1;
      end else if (big || t >= lim) begin
        // at or past the last node: last cell, full fraction
        l.idx  = nm1 - LIW'(1);
        l.frac = FRAC_ONE;
        l.oor  = big || (t > lim);
      end else begin
        l.idx  = t[16 +: LIW];
        l.frac = {1'b0, t[15:0]};
      end
    end
    return l;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] x_origin, r_origin, x_scale, r_scale;
  logic [47:0] value_floor;
  logic [7:0]  used_cols, used_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin    <= RST_X_ORIGIN;
      r_origin    <= RST_R_ORIGIN;
      x_scale     <= RST_X_SCALE;
      r_scale     <= RST_R_SCALE;
      value_floor <= RST_VALUE_FLOOR;
      used_cols   <= RST_USED_COLS;
      used_rows   <= RST_USED_ROWS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_X_ORIGIN:    x_origin    <= cfg_data[31:0];
        REG_R_ORIGIN:    r_origin    <= cfg_data[31:0];
        REG_X_SCALE:     x_scale     <= cfg_data[31:0];
        REG_R_SCALE:     r_scale     <= cfg_data[31:0];
        REG_VALUE_FLOOR: value_floor <= cfg_data[47:0];
        REG_USED_COLS:   used_cols   <= cfg_data[7:0];
        REG_USED_ROWS:   used_rows   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // node counts clamped into 2..grid size, kept as last node index
  logic [15:0]    ncol16, nrow16;
  logic [LIW-1:0] xnm1, rnm1;

  always_comb begin
    if (used_cols < 8'd2)                  ncol16 = 16'd2;
    else if ({8'd0, used_cols} > 16'(GRID_COLS)) ncol16 = 16'(GRID_COLS);
    else                                   ncol16 = {8'd0, used_cols};
    if (used_rows < 8'd2)                  nrow16 = 16'd2;
    else if ({8'd0, used_rows} > 16'(GRID_ROWS)) nrow16 = 16'(GRID_ROWS);
    else                                   nrow16 = {8'd0, used_rows};
    xnm1 = LIW'(ncol16 - 16'd1);
    rnm1 = LIW'(nrow16 - 16'd1);
  end

  // ---------------------------------------------------------------------------
  // global advance: the whole pipe moves unless the output buffer is full
  // ---------------------------------------------------------------------------
  logic [1:0] sk_cnt;
  logic       adv;

  assign adv      = (sk_cnt != 2'd2);
  assign in_ready = adv;

  // ---------------------------------------------------------------------------
  // s0: capture, absolute values of y and z, axial offset
  // ---------------------------------------------------------------------------
  logic        s0_v, s0_op;
  logic [6:0]  s0_row, s0_col;
  logic [47:0] s0_val;
  logic [33:0] s0_dx;
  logic [31:0] s0_ay, s0_az;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (adv) begin
      s0_v   <= in_valid;
      s0_op  <= in_item.operation;
      s0_row <= in_item.entry_row;
      s0_col <= in_item.entry_col;
      s0_val <= in_item.entry_value;
      s0_dx  <= {{2{in_item.point_x[31]}}, in_item.point_x}
              - {{2{x_origin[31]}}, x_origin};
      s0_ay  <= in_item.point_y[31] ? 32'(-in_item.point_y) : in_item.point_y;
      s0_az  <= in_item.point_z[31] ? 32'(-in_item.point_z) : in_item.point_z;
    end
  end

  // ---------------------------------------------------------------------------
  // s1: squares and the axial scaling product
  // ---------------------------------------------------------------------------
  logic        s1_v, s1_op, s1_xneg, s1_xbig;
  logic [6:0]  s1_row, s1_col;
  logic [47:0] s1_val;
  logic [63:0] s1_sqy, s1_sqz, s1_xprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v     <= s0_v;
      s1_op    <= s0_op;
      s1_row   <= s0_row;
      s1_col   <= s0_col;
      s1_val   <= s0_val;
      s1_sqy   <= 64'(s0_ay) * 64'(s0_ay);
      s1_sqz   <= 64'(s0_az) * 64'(s0_az);
      s1_xprod <= 64'(s0_dx[31:0]) * 64'(x_scale);
      s1_xneg  <= s0_dx[33];
      s1_xbig  <= !s0_dx[33] && s0_dx[32];
    end
  end

  // ---------------------------------------------------------------------------
  // s2: radius squared, axial cell and fraction; feeds the root pipe
  // ---------------------------------------------------------------------------
  loc_t xloc;
  assign xloc = locate(x_scale == 32'd0, s1_xneg, s1_xbig, s1_xprod[63:24], xnm1);

  logic vq [SQ_STAGES+1];
  sq_t  sq_q [SQ_STAGES+1];
  cry_t cq [SQ_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vq[0] <= 1'b0;
    end else if (adv) begin
      vq[0]   <= s1_v;
      sq_q[0] <= '{rem: '0, root: '0, rad: s1_sqy + s1_sqz};
      cq[0]   <= '{op: s1_op, row: s1_row, col: s1_col, val: s1_val,
                   cx: CIW'(xloc.idx), fx: xloc.frac, oorx: xloc.oor};
    end
  end

  // square root, two bits a stage
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
    sq_t s_mid, s_nxt;
    assign s_mid = sq_step(sq_q[k]);
    assign s_nxt = sq_step(s_mid);
    always_ff @(posedge clk) begin
      if (rst) begin
        vq[k+1] <= 1'b0;
      end else if (adv) begin
        vq[k+1]   <= vq[k];
        sq_q[k+1] <= s_nxt;
        cq[k+1]   <= cq[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // a: radial offset, b: radial product, c: radial cell and fraction
  // ---------------------------------------------------------------------------
  logic        a_v, b_v, c_v, b_rneg, b_rbig, c_oor;
  cry_t        a_c, b_c, c_c;
  logic [33:0] a_dr;
  logic [63:0] b_rprod;
  logic [RIW-1:0] c_cr;
  logic [16:0]    c_fr;
  loc_t rloc;

  assign rloc = locate(r_scale == 32'd0, b_rneg, b_rbig, b_rprod[63:24], rnm1);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else if (adv) begin
      a_v     <= vq[SQ_STAGES];
      a_c     <= cq[SQ_STAGES];
      a_dr    <= {2'b00, sq_q[SQ_STAGES].root} - {{2{r_origin[31]}}, r_origin};
      b_v     <= a_v;
      b_c     <= a_c;
      b_rprod <= 64'(a_dr[31:0]) * 64'(r_scale);
      b_rneg  <= a_dr[33];
      b_rbig  <= !a_dr[33] && a_dr[32];
      c_v     <= b_v;
      c_c     <= b_c;
      c_oor   <= b_c.oorx || rloc.oor;
      c_cr    <= RIW'(rloc.idx);
      c_fr    <= rloc.frac;
    end
  end

  // ---------------------------------------------------------------------------
  // d: bank addresses for the four corners, or the bank write of a write item
  // writes happen here, in item order with the reads
  // ---------------------------------------------------------------------------
  logic [AW-1:0] rd_addr_n [4];
  logic [AW-1:0] wr_addr_n;

  for (genvar b = 0; b < 4; b++) begin : g_addr
    logic [RIW:0] rrow;
    logic [CIW:0] rcol;
    assign rrow = (c_cr[0] == b[1]) ? {1'b0, c_cr} : {1'b0, c_cr} + (RIW+1)'(1);
    assign rcol = (c_c.cx[0] == b[0]) ? {1'b0, c_c.cx} : {1'b0, c_c.cx} + (CIW+1)'(1);
    assign rd_addr_n[b] = AW'(rrow >> 1) * AW'(HC) + AW'(rcol >> 1);
  end

  assign wr_addr_n = AW'(c_c.row[6:1]) * AW'(HC) + AW'(c_c.col[6:1]);

  logic          d_v, d_op, d_wok, d_cr0, d_cx0, d_oor;
  logic [1:0]    d_wbank;
  logic [AW-1:0] d_raddr [4];
  logic [AW-1:0] d_waddr;
  logic [47:0]   d_wdata;
  logic [16:0]   d_fx, d_fr;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (adv) begin
      d_v     <= c_v;
      d_op    <= c_c.op;
      d_wok   <= (11'(c_c.row) < 11'(GRID_ROWS)) && (11'(c_c.col) < 11'(GRID_COLS));
      d_wbank <= {c_c.row[0], c_c.col[0]};
      d_waddr <= wr_addr_n;
      d_wdata <= c_c.val;
      d_raddr <= rd_addr_n;
      d_cr0   <= c_cr[0];
      d_cx0   <= c_c.cx[0];
      d_fx    <= c_c.fx;
      d_fr    <= c_fr;
      d_oor   <= c_oor;
    end
  end

  // four banks; bank index is {row parity, column parity}
  logic [47:0] rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    rgbi_ram #(
      .WIDTH (48),
      .DEPTH (BDEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (adv && d_v && d_op == OP_WRITE && d_wok && d_wbank == 2'(b)),
      .waddr (d_waddr),
      .wdata (d_wdata),
      .re    (adv),
      .raddr (d_raddr[b]),
      .rdata (rd[b])
    );
  end

  // ---------------------------------------------------------------------------
  // e: bank data arrives; only queries carry on from here
  // ---------------------------------------------------------------------------
  logic        e_v, e_cr0, e_cx0, e_oor;
  logic [16:0] e_fx, e_fr;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v   <= d_v && d_op == OP_QUERY;
      e_cr0 <= d_cr0;
      e_cx0 <= d_cx0;
      e_fx  <= d_fx;
      e_fr  <= d_fr;
      e_oor <= d_oor;
    end
  end

  // corners: a/b on the lower row, c/d on the upper, b/d on the right column
  logic [47:0] ca, cb, cc, cd;
  assign ca = rd[{e_cr0, e_cx0}];
  assign cb = rd[{e_cr0, !e_cx0}];
  assign cc = rd[{!e_cr0, e_cx0}];
  assign cd = rd[{!e_cr0, !e_cx0}];

  // ---------------------------------------------------------------------------
  // f/g: blend along x on both rows; h/i: blend along r
  // ---------------------------------------------------------------------------
  logic        f_v, g_v, h_v, i_v, f_oor, g_oor, h_oor, i_oor;
  logic [16:0] f_fr, g_fr;
  logic [64:0] f_p0, f_p1, f_p2, f_p3, h_q0, h_q1;
  logic [47:0] g_bot, g_top, i_val;
  logic [64:0] f_sum_lo, f_sum_hi, h_sum;

  assign f_sum_lo = f_p0 + f_p1;
  assign f_sum_hi = f_p2 + f_p3;
  assign h_sum    = h_q0 + h_q1;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
      g_v <= 1'b0;
      h_v <= 1'b0;
      i_v <= 1'b0;
    end else if (adv) begin
      f_v   <= e_v;
      f_oor <= e_oor;
      f_fr  <= e_fr;
      f_p0  <= 65'(ca) * 65'(FRAC_ONE - e_fx);
      f_p1  <= 65'(cb) * 65'(e_fx);
      f_p2  <= 65'(cc) * 65'(FRAC_ONE - e_fx);
      f_p3  <= 65'(cd) * 65'(e_fx);
      g_v   <= f_v;
      g_oor <= f_oor;
      g_fr  <= f_fr;
      g_bot <= f_sum_lo[63:16];
      g_top <= f_sum_hi[63:16];
      h_v   <= g_v;
      h_oor <= g_oor;
      h_q0  <= 65'(g_bot) * 65'(FRAC_ONE - g_fr);
      h_q1  <= 65'(g_top) * 65'(g_fr);
      i_v   <= h_v;
      i_oor <= h_oor;
      i_val <= h_sum[63:16];
    end
  end

  // ---------------------------------------------------------------------------
  // output buffer, two entries; the floor is applied on the way in
  // ---------------------------------------------------------------------------
  out_item_t sk_mem [2];
  logic      sk_wp, sk_rp, push, pop;

  assign push = adv && i_v;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sk_cnt <= 2'd0;
      sk_wp  <= 1'b0;
      sk_rp  <= 1'b0;
    end else begin
      if (push) begin
        sk_mem[sk_wp] <= '{interpolated_value: (i_val < value_floor) ? value_floor : i_val,
                           out_of_range: i_oor};
        sk_wp <= !sk_wp;
      end
      if (pop) begin
        sk_rp <= !sk_rp;
      end
      sk_cnt <= sk_cnt + 2'(push) - 2'(pop);
    end
  end

  assign out_valid = (sk_cnt != 2'd0);
  assign out_item  = sk_mem[sk_rp];

endmodule

`default_nettype wire

// ===== hw/rtl/rgbi_chk.sv =====
// rgbi_chk: port-level checks of the radial grid interpolator, bound to the top level
// depends on rgbi_pkg and radial_grid_bilinear_interp
`default_nettype none

module rgbi_chk (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire rgbi_pkg::out_item_t             out_item,
  input wire logic                            cfg_write,
  input wire logic [rgbi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [rgbi_pkg::CFG_DATA_W-1:0] cfg_data
);

  import rgbi_pkg::*;

  // floor as last written through the port
  logic [47:0] floor_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_seen <= RST_VALUE_FLOOR;
    end else if (cfg_write && cfg_index == REG_VALUE_FLOOR) begin
      floor_seen <= cfg_data[47:0];
    end
  end

  // results never drop below the floor
  a_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.interpolated_value >= floor_seen)
    else $error("result below floor");

  // input stalls only while a result is pending
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("pending result changed");

endmodule

bind radial_grid_bilinear_interp rgbi_chk u_rgbi_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item),
  .cfg_write (cfg_write),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

`default_nettype wire
